[rtl/core/tbbl_pkg.sv]
// Shared types, widths and defaults for the token bucket byte limiter.
package tbbl_pkg;

   localparam int FILL_W  = 32;
   localparam int COUNT_W = 32;
   localparam int LEVEL_W = 42;
   localparam int WHOLE_W = 34;

   localparam int DEF_TICKS_PER_SECOND = 1024;
   localparam int DEF_FRAC_BITS        = 8;
   localparam int DEF_MIN_BURST_BYTES  = 131072;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SEND = 1'b1;

   typedef struct packed {
      logic               op;
      logic [COUNT_W-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic               over_cap;
      logic [WHOLE_W-1:0] whole_bytes_left;
   } rsp_type;

   typedef struct packed {
      logic               unlimited;
      logic [FILL_W-1:0]  fill_per_tick;
      logic [LEVEL_W-1:0] cap;
   } cfg_type;

endpackage

[rtl/core/token_bucket_byte_limiter_unit.sv]
// Token bucket byte limiter: top level with input, bucket and result registers.
// Items pass the input register, then the result register; an item waits in the
// input register while the result register holds a result that is not yet taken.
// Throughput: one item per cycle while rsp_ready is high; bucket math is combinational.
// Reset (synchronous, active high) empties the bucket, sets fill to zero (unlimited)
// and clears both valid flags.
module token_bucket_byte_limiter_unit #(
   parameter int TICKS_PER_SECOND = tbbl_pkg::DEF_TICKS_PER_SECOND,
   parameter int FRAC_BITS        = tbbl_pkg::DEF_FRAC_BITS,
   parameter int MIN_BURST_BYTES  = tbbl_pkg::DEF_MIN_BURST_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [tbbl_pkg::FILL_W-1:0] csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tbbl_pkg::req_type           req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tbbl_pkg::rsp_type           rsp_item
);
   import tbbl_pkg::*;

   cfg_type            cfg;
   logic               in_valid_ff;
   logic               in_valid_in;
   req_type            in_item_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_item_ff;
   rsp_type            result;
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic [LEVEL_W-1:0] level_next;
   logic               advance;

   tbbl_cfg #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND),
      .FRAC_BITS        (FRAC_BITS),
      .MIN_BURST_BYTES  (MIN_BURST_BYTES)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tbbl_meter #(
      .FRAC_BITS (FRAC_BITS)
   ) u_meter (
      .cfg        (cfg),
      .level      (level_ff),
      .item       (in_item_ff),
      .level_next (level_next),
      .result     (result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      level_in     = level_ff;
      if (csr_wen && (csr_wdata == '0)) begin
         level_in = '0;
      end else if (advance) begin
         level_in = level_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[rtl/core/tbbl_cfg.sv]
// Fill register and bucket cap, computed when the fill is written.
module tbbl_cfg #(
   parameter int TICKS_PER_SECOND = tbbl_pkg::DEF_TICKS_PER_SECOND,
   parameter int FRAC_BITS        = tbbl_pkg::DEF_FRAC_BITS,
   parameter int MIN_BURST_BYTES  = tbbl_pkg::DEF_MIN_BURST_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [tbbl_pkg::FILL_W-1:0] csr_wdata,
   output tbbl_pkg::cfg_type           cfg
);
   import tbbl_pkg::*;

   localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_W = FILL_W + TPS_W;
   localparam int HALF_W = PROD_W - 1;
   localparam int CMP_W  = (HALF_W > LEVEL_W) ? HALF_W : LEVEL_W;
   localparam logic [CMP_W-1:0] FLOOR_UNITS =
      CMP_W'(MIN_BURST_BYTES) << FRAC_BITS;
   localparam logic [CMP_W-1:0] LEVEL_MAX = CMP_W'({LEVEL_W{1'b1}});

   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic [LEVEL_W-1:0] cap_ff;
   logic [LEVEL_W-1:0] cap_in;
   logic [PROD_W-1:0]  prod;
   logic [CMP_W-1:0]   half_w;
   logic [CMP_W-1:0]   cap_w;

   assign prod   = PROD_W'(csr_wdata) * PROD_W'(TICKS_PER_SECOND);
   assign half_w = CMP_W'(prod[PROD_W-1:1]);
   assign cap_w  = (half_w > FLOOR_UNITS) ? half_w : FLOOR_UNITS;

   always_comb begin
      fill_in = fill_ff;
      cap_in  = cap_ff;
      if (csr_wen) begin
         fill_in = csr_wdata;
         cap_in  = (cap_w > LEVEL_MAX) ? LEVEL_MAX[LEVEL_W-1:0] : cap_w[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cap_ff  <= FLOOR_UNITS[LEVEL_W-1:0];
      end else begin
         fill_ff <= fill_in;
         cap_ff  <= cap_in;
      end
   end

   assign cfg.unlimited     = (fill_ff == '0);
   assign cfg.fill_per_tick = fill_ff;
   assign cfg.cap           = cap_ff;

endmodule

[rtl/core/tbbl_meter.sv]
// Bucket update and result for one item.
module tbbl_meter #(
   parameter int FRAC_BITS = tbbl_pkg::DEF_FRAC_BITS
) (
   input  tbbl_pkg::cfg_type            cfg,
   input  logic [tbbl_pkg::LEVEL_W-1:0] level,
   input  tbbl_pkg::req_type            item,
   output logic [tbbl_pkg::LEVEL_W-1:0] level_next,
   output tbbl_pkg::rsp_type            result
);
   import tbbl_pkg::*;

   localparam int NEED_W = COUNT_W + FRAC_BITS;
   localparam int CW     = (NEED_W > LEVEL_W) ? NEED_W : LEVEL_W;

   logic [LEVEL_W:0]   sum;
   logic [LEVEL_W-1:0] clamped;
   logic [CW-1:0]      need_w;
   logic [CW-1:0]      cap_w;
   logic [CW-1:0]      clamped_w;
   logic [LEVEL_W-1:0] shifted;
   logic               grant;
   logic               over;

   assign sum       = {1'b0, level} + (LEVEL_W + 1)'(cfg.fill_per_tick);
   assign clamped   = (level > cfg.cap) ? cfg.cap : level;
   assign need_w    = CW'(item.byte_count) << FRAC_BITS;
   assign cap_w     = CW'(cfg.cap);
   assign clamped_w = CW'(clamped);

   always_comb begin
      level_next = level;
      grant      = 1'b0;
      over       = 1'b0;
      if (cfg.unlimited) begin
         level_next = '0;
         grant      = (item.op == OP_SEND);
      end else if (item.op == OP_TICK) begin
         level_next = (sum > (LEVEL_W + 1)'(cfg.cap)) ? cfg.cap : sum[LEVEL_W-1:0];
      end else if (item.byte_count == '0) begin
         grant = 1'b1;
      end else begin
         over       = (need_w > cap_w);
         level_next = clamped;
         if (clamped_w >= need_w) begin
            grant      = 1'b1;
            level_next = clamped - need_w[LEVEL_W-1:0];
         end
      end
   end

   assign shifted = level_next >> FRAC_BITS;

   assign result.granted          = grant;
   assign result.over_cap         = over;
   assign result.whole_bytes_left = (|shifted[LEVEL_W-1:WHOLE_W]) ? {WHOLE_W{1'b1}}
                                                                   : shifted[WHOLE_W-1:0];

endmodule

[rtl/core/tbbl_checker.sv]
// Port-level checks for the token bucket byte limiter, bound to the top level.
module tbbl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input tbbl_pkg::req_type           req_item,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input tbbl_pkg::rsp_type           rsp_item
);
   import tbbl_pkg::*;

   // a waiting input item stays
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_item))
      else $error("req item dropped or changed while waiting");

   // a stalled result item stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_item))
      else $error("rsp item changed while stalled");

   // a grant needs need <= level <= cap, so it cannot be over cap
   a_grant_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.granted && rsp_item.over_cap))
      else $error("item both granted and over cap");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind token_bucket_byte_limiter_unit tbbl_checker u_tbbl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

[tb/tb.sv]
// Self-checking testbench for the token bucket byte limiter: directed and random items.
`timescale 1ns / 100ps

module tb;
   import tbbl_pkg::*;

   localparam int TPS         = DEF_TICKS_PER_SECOND;
   localparam int FRAC        = DEF_FRAC_BITS;
   localparam int MIN_BURST   = DEF_MIN_BURST_BYTES;
   localparam int STALL_LIMIT = 2000;
   localparam logic [63:0] LEVEL_MAX = (64'd1 << LEVEL_W) - 64'd1;
   localparam logic [63:0] WHOLE_MAX = (64'd1 << WHOLE_W) - 64'd1;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wen;
   logic [FILL_W-1:0]  csr_wdata;
   logic               req_valid;
   logic               req_ready;
   req_type            req_item;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_item;

   logic [FILL_W-1:0]  fill_rate;
   logic [63:0]        bucket;
   rsp_type            expected_rsp[$];
   int                 fail_count;
   int                 src_gap_max;
   int                 sink_gap_max;
   int                 hold_cycles;
   int                 idle_cycles;

   token_bucket_byte_limiter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] bucket_cap();
      logic [63:0] half;
      logic [63:0] floor_units;
      logic [63:0] cap;
      half        = ({32'b0, fill_rate} * 64'(TPS)) >> 1;
      floor_units = 64'(MIN_BURST) << FRAC;
      cap         = (half > floor_units) ? half : floor_units;
      return (cap > LEVEL_MAX) ? LEVEL_MAX : cap;
   endfunction

   function automatic rsp_type meter_item(req_type it);
      logic [63:0] cap;
      logic [63:0] need;
      logic [63:0] whole;
      rsp_type     res;
      res = '0;
      if (fill_rate == '0) begin
         bucket = '0;
         if (it.op == OP_SEND) res.granted = 1'b1;
      end else begin
         cap = bucket_cap();
         if (it.op == OP_TICK) begin
            bucket = bucket + {32'b0, fill_rate};
            if (bucket > cap) bucket = cap;
         end else if (it.byte_count == '0) begin
            res.granted = 1'b1;
         end else begin
            need = {32'b0, it.byte_count} << FRAC;
            if (bucket > cap) bucket = cap;
            if (need > cap) res.over_cap = 1'b1;
            if (bucket >= need) begin
               bucket      = bucket - need;
               res.granted = 1'b1;
            end
         end
      end
      bucket = bucket & LEVEL_MAX;
      whole  = bucket >> FRAC;
      if (whole > WHOLE_MAX) whole = WHOLE_MAX;
      res.whole_bytes_left = whole[WHOLE_W-1:0];
      return res;
   endfunction

   function automatic req_type mk_item(logic op, logic [COUNT_W-1:0] n);
      req_type it;
      it.op         = op;
      it.byte_count = n;
      return it;
   endfunction

   // near_pct: share of requests sized close to the current bucket level
   function automatic req_type random_item(int tick_pct, int near_pct);
      req_type     it;
      logic [63:0] whole;
      int          pick;
      whole   = bucket >> FRAC;
      it.op   = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_SEND;
      pick    = $urandom_range(0, 99);
      if (pick < 5)
         it.byte_count = '0;
      else if (pick < 15 || whole > 64'hFFFF_FFF0)
         it.byte_count = $urandom;
      else if (pick < 15 + near_pct)
         it.byte_count = whole[31:0] + 32'($urandom_range(0, 8)) - 32'd4;
      else
         it.byte_count = $urandom_range(1, 255);
      return it;
   endfunction

   task automatic send_item(req_type it);
      int gap;
      gap = $urandom_range(0, src_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(meter_item(it));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_fill(logic [FILL_W-1:0] value);
      drain();
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      fill_rate = value;
      if (value == '0) bucket = '0;
   endtask

   task automatic run_phase(logic [FILL_W-1:0] fill, int n, int tick_pct, int near_pct);
      write_fill(fill);
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      repeat (n) send_item(random_item(tick_pct, near_pct));
   endtask

   task automatic test_unlimited();
      send_item(mk_item(OP_TICK, 32'd0));
      send_item(mk_item(OP_SEND, 32'd0));
      send_item(mk_item(OP_SEND, 32'd1));
      send_item(mk_item(OP_SEND, 32'hFFFF_FFFF));
   endtask

   task automatic test_grant_refuse();
      write_fill(32'd256);
      repeat (3) send_item(mk_item(OP_TICK, 32'hFFFF_FFFF));
      send_item(mk_item(OP_SEND, 32'd2));
      send_item(mk_item(OP_SEND, 32'd5));
      send_item(mk_item(OP_SEND, 32'd0));
      send_item(mk_item(OP_SEND, 32'd131073));
      send_item(mk_item(OP_SEND, 32'hFFFF_FFFF));
      send_item(mk_item(OP_SEND, 32'd131072));
   endtask

   task automatic test_cap_lowered();
      write_fill(32'hFFFF_FFFF);
      send_item(mk_item(OP_TICK, 32'd0));
      send_item(mk_item(OP_TICK, 32'd0));
      send_item(mk_item(OP_SEND, 32'hFFFF_FFFF));
      send_item(mk_item(OP_SEND, 32'h00FF_FFFF));
      write_fill(32'd1);
      send_item(mk_item(OP_SEND, 32'd1));
      send_item(mk_item(OP_TICK, 32'd0));
      write_fill(32'd0);
      send_item(mk_item(OP_TICK, 32'd0));
      send_item(mk_item(OP_SEND, 32'd7));
   endtask

   task automatic test_saturation();
      run_phase(32'hFFFF_FFFF, 650, 95, 0);
      run_phase(32'h0000_FFFF, 650, 95, 0);
   endtask

   task automatic test_random_rates();
      logic [FILL_W-1:0] fill;
      int                sel;
      repeat (4) begin
         sel = $urandom_range(0, 4);
         case (sel)
            0: fill = '0;
            1: fill = 32'd1;
            2: fill = $urandom_range(1, 32'hFFFF);
            3: fill = $urandom;
            default: fill = 32'hFFFF_FFFF;
         endcase
         run_phase(fill, 80, 50, 45);
      end
   endtask

   task automatic test_backpressure();
      write_fill(32'h0001_0000);
      src_gap_max  = 0;
      sink_gap_max = 0;
      hold_cycles  = 300;
      repeat (40) send_item(random_item(50, 45));
      src_gap_max  = 10;
      sink_gap_max = 10;
   endtask

   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            gap         = hold_cycles;
            hold_cycles = 0;
         end else begin
            gap = $urandom_range(0, sink_gap_max);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t unexpected item: expected none actual %p", $time, rsp_item);
            fail_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_item.granted !== want.granted) begin
               $display("%0t granted: expected %0d actual %0d",
                        $time, want.granted, rsp_item.granted);
               fail_count++;
            end
            if (rsp_item.over_cap !== want.over_cap) begin
               $display("%0t over_cap: expected %0d actual %0d",
                        $time, want.over_cap, rsp_item.over_cap);
               fail_count++;
            end
            if (rsp_item.whole_bytes_left !== want.whole_bytes_left) begin
               $display("%0t whole_bytes_left: expected %0d actual %0d",
                        $time, want.whole_bytes_left, rsp_item.whole_bytes_left);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      csr_wen      = 1'b0;
      csr_wdata    = '0;
      req_valid    = 1'b0;
      req_item     = '0;
      fail_count   = 0;
      idle_cycles  = 0;
      hold_cycles  = 0;
      src_gap_max  = 10;
      sink_gap_max = 10;
      fill_rate    = '0;
      bucket       = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unlimited();
      test_grant_refuse();
      test_cap_lowered();
      test_saturation();
      test_random_rates();
      test_backpressure();
      drain();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
